/* hdl/pse_pkg.sv */
// Shared types, constants and the CRC-32 byte step of the PNG stored greyscale encoder.
`default_nettype none
package pse_pkg;

  localparam int DIM_W = 13;
  localparam int RAW_W = 26;
  localparam int CNT_W = 6;
  localparam int IDX_W = 6;

  // Largest width or height; it must fit DIM_W bits.
  localparam int MAX_DIMENSION = 4096;

  localparam logic [CNT_W-1:0] RESULT_LIMIT = 6'd50;
  localparam logic [IDX_W-1:0] HDR_LAST = 6'd42;
  localparam logic [IDX_W-1:0] TRL_LAST = 6'd19;
  localparam logic [IDX_W-1:0] BLK_LAST = 6'd4;
  localparam logic [IDX_W-1:0] HDR_IDAT_LEN = 6'd33;
  localparam logic [IDX_W-1:0] HDR_IHDR_TAG = 6'd12;
  localparam logic [IDX_W-1:0] HDR_IDAT_TAG = 6'd37;
  localparam logic [IDX_W-1:0] TRL_IEND_TAG = 6'd12;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam logic [2:0] CFG_ADDR_WIDTH = 3'd0;
  localparam logic [2:0] CFG_ADDR_HEIGHT = 3'd4;

  // One pixel with its position flags and the frame's dimensions.
  typedef struct packed {
    logic [7:0]       pixel;
    logic             sof;
    logic             sor;
    logic             eof;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } pse_cmd_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hdl/pse_queue.sv */
// Short command queue between the pixel classifier and the byte sequencer.
`default_nettype none
module pse_queue
  import pse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  pse_cmd_t      push_cmd,
  output logic          full,
  input  wire logic     pop,
  output logic          valid,
  output pse_cmd_t      head
);

  pse_cmd_t   mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full  = (cnt_r == 3'd4);
  assign valid = (cnt_r != 3'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, push} - {2'd0, pop};
    end
  end

endmodule
`default_nettype wire

/* hdl/pse_front.sv */
// Pixel intake: latches frame dimensions and tags each pixel with its position.
`default_nettype none
module pse_front
  import pse_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,
  input  wire logic [DIM_W-1:0] cfg_w,
  input  wire logic [DIM_W-1:0] cfg_h,
  input  wire logic             q_full,
  output logic                  push,
  output pse_cmd_t              push_cmd
);

  logic             active_r;
  logic [DIM_W-1:0] col_r, row_r, fw_r, fh_r;
  logic [DIM_W-1:0] cw, ch, fw, fh, col, row;
  logic [DIM_W:0]   col_inc, row_inc;
  logic             row_end, eof;

  function automatic logic [DIM_W-1:0] clamp(input logic [DIM_W-1:0] v,
                                             input logic [DIM_W-1:0] lo);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < lo) r = lo;
    else if ({19'd0, v} > 32'(MAX_DIMENSION)) r = DIM_W'(MAX_DIMENSION);
    return r;
  endfunction

  assign cw = clamp(cfg_w, 13'd2);
  assign ch = clamp(cfg_h, 13'd1);
  assign fw  = active_r ? fw_r : cw;
  assign fh  = active_r ? fh_r : ch;
  assign col = active_r ? col_r : '0;
  assign row = active_r ? row_r : '0;
  assign col_inc = {1'b0, col} + 14'd1;
  assign row_inc = {1'b0, row} + 14'd1;
  assign row_end = col_inc >= {1'b0, fw};
  assign eof = row_end && (row_inc >= {1'b0, fh});

  assign in_tready = !q_full;
  assign push = in_tvalid && in_tready;

  always_comb begin
    push_cmd.pixel = in_tdata;
    push_cmd.sof   = !active_r;
    push_cmd.sor   = (col == '0);
    push_cmd.eof   = eof;
    push_cmd.w     = fw;
    push_cmd.h     = fh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      fw_r     <= 13'd2;
      fh_r     <= 13'd1;
    end else if (push) begin
      fw_r     <= fw;
      fh_r     <= fh;
      active_r <= !eof;
      col_r    <= row_end ? '0 : col_inc[DIM_W-1:0];
      row_r    <= row_end ? row_inc[DIM_W-1:0] : row;
    end
  end

endmodule
`default_nettype wire

/* hdl/pse_back.sv */
// Byte sequencer: emits headers, stored-block framing, pixels and trailers with CRC and Adler.
`default_nettype none
module pse_back
  import pse_pkg::*;
#(
  parameter int STORED_BLOCK_MAX = 65535
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  pse_cmd_t        q_cmd,
  output logic            q_pop,
  input  wire logic       out_tready,
  output logic            out_tvalid,
  output logic [7:0]      out_tdata,
  output logic            out_tlast,
  output logic [0:0]      out_tuser
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HDR  = 3'd1;
  localparam logic [2:0] PH_BLK  = 3'd2;
  localparam logic [2:0] PH_RAW  = 3'd3;
  localparam logic [2:0] PH_TRL  = 3'd4;

  localparam logic [16:0] BMAX = 17'(STORED_BLOCK_MAX);

  // Rounded-up reciprocal of the block size, exact for any dividend below 2**RAW_W.
  localparam int DIV_L = $clog2(STORED_BLOCK_MAX);
  localparam int DIV_S = RAW_W + DIV_L;
  localparam logic [63:0] DIV_M_W =
    ((64'd1 << DIV_S) + 64'(STORED_BLOCK_MAX) - 64'd1) / 64'(STORED_BLOCK_MAX);
  localparam logic [27:0] DIV_M = DIV_M_W[27:0];

  logic [2:0]       ph_r, ph, ph_nxt;
  logic [IDX_W-1:0] idx_r, idx, idx_nxt;
  logic             filt_r, filt, filt_nxt;
  pse_cmd_t         cmd_r, cmd;
  logic [CNT_W-1:0] cnt_r, cnt;
  logic [31:0]      crc_r, crc_in, crc_nxt;
  logic [15:0]      alo_r, ahi_r, alo_nxt, ahi_nxt;
  logic [16:0]      alo_sum, ahi_sum;
  logic [15:0]      blk_r, blk_nxt, blk_dec, n;
  logic [RAW_W-1:0] raw_r, raw_nxt, mul_r, xdiv_r, nb_r;
  logic [39:0]      plo_r, phi_r;
  logic [53:0]      psum;
  logic [3:0]       lstg_r;
  logic             len_ok_r;
  logic [31:0]      len_r;
  logic             out_valid_r, out_last_r, out_file_r;
  logic [7:0]       out_data_r;
  logic [7:0]       b, rb;
  logic             crcf, tag, item_end, have, hold, adv, emit, last, fin;

  assign cmd  = (ph_r == PH_IDLE) ? q_cmd : cmd_r;
  assign cnt  = (ph_r == PH_IDLE) ? '0 : cnt_r;
  assign have = (ph_r != PH_IDLE) || q_valid;

  always_comb begin
    if (ph_r == PH_IDLE) begin
      idx  = '0;
      filt = q_cmd.sor;
      if (q_cmd.sof) ph = PH_HDR;
      else ph = (blk_r == 16'd0) ? PH_BLK : PH_RAW;
    end else begin
      idx  = idx_r;
      filt = filt_r;
      ph   = ph_r;
    end
  end

  assign hold  = (ph == PH_HDR) && (idx >= HDR_IDAT_LEN) && !len_ok_r;
  assign adv   = have && !hold && (!out_valid_r || out_tready);
  assign q_pop = adv && (ph_r == PH_IDLE);

  assign n  = ({{(RAW_W-17){1'b0}}, BMAX} < raw_r) ? BMAX[15:0] : raw_r[15:0];
  assign fin = (raw_r <= {{(RAW_W-17){1'b0}}, BMAX});
  assign rb = filt ? 8'd0 : cmd.pixel;

  // Byte selection and CRC coverage for the current position.
  always_comb begin
    b = 8'd0;
    crcf = 1'b1;
    tag = 1'b0;
    unique case (ph)
      PH_HDR: begin
        crcf = ((idx >= 6'd12) && (idx <= 6'd28)) || (idx >= HDR_IDAT_TAG);
        tag  = (idx == HDR_IHDR_TAG) || (idx == HDR_IDAT_TAG);
        unique case (idx)
          6'd0: b = 8'h89;  6'd1: b = 8'h50;  6'd2: b = 8'h4E;  6'd3: b = 8'h47;
          6'd4: b = 8'h0D;  6'd5: b = 8'h0A;  6'd6: b = 8'h1A;  6'd7: b = 8'h0A;
          6'd11: b = 8'h0D;
          6'd12: b = 8'h49; 6'd13: b = 8'h48; 6'd14: b = 8'h44; 6'd15: b = 8'h52;
          6'd18: b = {3'd0, cmd.w[12:8]};
          6'd19: b = cmd.w[7:0];
          6'd22: b = {3'd0, cmd.h[12:8]};
          6'd23: b = cmd.h[7:0];
          6'd24: b = 8'h08;
          6'd29: b = ~crc_r[31:24]; 6'd30: b = ~crc_r[23:16];
          6'd31: b = ~crc_r[15:8];  6'd32: b = ~crc_r[7:0];
          6'd33: b = len_r[31:24];  6'd34: b = len_r[23:16];
          6'd35: b = len_r[15:8];   6'd36: b = len_r[7:0];
          6'd37: b = 8'h49; 6'd38: b = 8'h44; 6'd39: b = 8'h41; 6'd40: b = 8'h54;
          6'd41: b = 8'h78; 6'd42: b = 8'h01;
          default: b = 8'h00;
        endcase
      end
      PH_BLK: begin
        unique case (idx)
          6'd0: b = {7'd0, fin};
          6'd1: b = n[7:0];
          6'd2: b = n[15:8];
          6'd3: b = ~n[7:0];
          default: b = ~n[15:8];
        endcase
      end
      PH_RAW: b = rb;
      PH_TRL: begin
        crcf = (idx <= 6'd3) || ((idx >= TRL_IEND_TAG) && (idx <= 6'd15));
        tag  = (idx == TRL_IEND_TAG);
        unique case (idx)
          6'd0: b = ahi_r[15:8]; 6'd1: b = ahi_r[7:0];
          6'd2: b = alo_r[15:8]; 6'd3: b = alo_r[7:0];
          6'd4: b = ~crc_r[31:24]; 6'd5: b = ~crc_r[23:16];
          6'd6: b = ~crc_r[15:8];  6'd7: b = ~crc_r[7:0];
          6'd12: b = 8'h49; 6'd13: b = 8'h45; 6'd14: b = 8'h4E; 6'd15: b = 8'h44;
          6'd16: b = ~crc_r[31:24]; 6'd17: b = ~crc_r[23:16];
          6'd18: b = ~crc_r[15:8];  6'd19: b = ~crc_r[7:0];
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
  end

  assign crc_in  = tag ? 32'hFFFFFFFF : crc_r;
  assign crc_nxt = crcf ? crc_byte(crc_in, b) : crc_r;

  assign alo_sum = {1'b0, alo_r} + {9'd0, rb};
  assign alo_nxt = (alo_sum >= ADLER_MOD) ? 16'(alo_sum - ADLER_MOD) : alo_sum[15:0];
  assign ahi_sum = {1'b0, ahi_r} + {1'b0, alo_nxt};
  assign ahi_nxt = (ahi_sum >= ADLER_MOD) ? 16'(ahi_sum - ADLER_MOD) : ahi_sum[15:0];
  assign blk_dec = blk_r - 16'd1;

  always_comb begin
    ph_nxt   = ph;
    idx_nxt  = idx + 6'd1;
    filt_nxt = filt;
    blk_nxt  = blk_r;
    raw_nxt  = raw_r;
    item_end = 1'b0;
    unique case (ph)
      PH_HDR: begin
        if (idx == HDR_LAST) begin
          ph_nxt   = PH_BLK;
          idx_nxt  = '0;
          filt_nxt = 1'b1;
          raw_nxt  = mul_r;
          blk_nxt  = 16'd0;
        end
      end
      PH_BLK: begin
        if (idx == BLK_LAST) begin
          ph_nxt  = PH_RAW;
          idx_nxt = '0;
          blk_nxt = n;
        end
      end
      PH_RAW: begin
        blk_nxt = blk_dec;
        raw_nxt = raw_r - 26'd1;
        idx_nxt = '0;
        if (filt) begin
          filt_nxt = 1'b0;
          ph_nxt   = (blk_dec == 16'd0) ? PH_BLK : PH_RAW;
        end else if (cmd.eof) begin
          ph_nxt = PH_TRL;
        end else begin
          ph_nxt   = PH_IDLE;
          item_end = 1'b1;
        end
      end
      PH_TRL: begin
        if (idx == TRL_LAST) begin
          ph_nxt   = PH_IDLE;
          item_end = 1'b1;
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  // Bytes past the per-pixel limit still advance the checksums but are not shown.
  assign emit = (cnt < RESULT_LIMIT);
  assign last = item_end || (cnt == RESULT_LIMIT - 6'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_IDLE;
      idx_r       <= '0;
      filt_r      <= 1'b0;
      cnt_r       <= '0;
      crc_r       <= 32'hFFFFFFFF;
      alo_r       <= 16'd1;
      ahi_r       <= 16'd0;
      blk_r       <= 16'd0;
      raw_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        ph_r        <= ph_nxt;
        idx_r       <= idx_nxt;
        filt_r      <= filt_nxt;
        cnt_r       <= cnt + {5'd0, emit};
        crc_r       <= crc_nxt;
        blk_r       <= blk_nxt;
        raw_r       <= raw_nxt;
        out_valid_r <= emit;
        if (ph == PH_RAW) begin
          alo_r <= alo_nxt;
          ahi_r <= ahi_nxt;
        end else if (ph == PH_HDR) begin
          alo_r <= 16'd1;
          ahi_r <= 16'd0;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r      <= cmd;
      out_data_r <= b;
      out_last_r <= last;
      out_file_r <= last && cmd.eof;
    end
  end

  // IDAT length: the block count is a rounded-up division by the block size, done as a
  // reciprocal multiply in four pipelined steps, well before the header needs it.
  assign psum = {phi_r, 14'd0} + {14'd0, plo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lstg_r   <= 4'd0;
      len_ok_r <= 1'b0;
    end else if (q_pop && q_cmd.sof) begin
      lstg_r   <= 4'b0001;
      len_ok_r <= 1'b0;
    end else begin
      lstg_r <= {lstg_r[2:0], 1'b0};
      if (lstg_r[3]) len_ok_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.sof) begin
      mul_r <= {12'd0, {1'b0, q_cmd.w} + 14'd1} * {13'd0, q_cmd.h};
    end
    if (lstg_r[0]) begin
      xdiv_r <= mul_r + RAW_W'(STORED_BLOCK_MAX - 1);
    end
    if (lstg_r[1]) begin
      plo_r <= {14'd0, xdiv_r} * {26'd0, DIV_M[13:0]};
      phi_r <= {14'd0, xdiv_r} * {26'd0, DIV_M[27:14]};
    end
    if (lstg_r[2]) begin
      nb_r <= RAW_W'(psum >> DIV_S);
    end
    if (lstg_r[3]) begin
      len_r <= 32'(mul_r) + {4'd0, nb_r, 2'b00} + 32'(nb_r) + 32'd6;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_file_r;

endmodule
`default_nettype wire

/* hdl/png_stored_greyscale_encoder.sv */
// A plain pixel passes through the command queue and the output register before it is shown.
// Throughput: one byte per cycle while out_tready is high; a plain pixel releases one byte,
// the first pixel of a row two, a new stored block adds five, the first pixel of a
// frame adds 43 header bytes and the last one adds 20 trailer bytes.
// The byte sequencer's single output port sets this rate.
// Reset (synchronous, active low) clears all control state and restores width 2, height 1.
`default_nettype none
module png_stored_greyscale_encoder
  import pse_pkg::*;
#(
  parameter int STORED_BLOCK_MAX = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] pixel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // [7:0] out_byte
  output logic             out_tlast,
  output logic [0:0]       out_tuser,   // [0] file_last
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [DIM_W-1:0] width_r, height_r;
  logic             q_full, push, q_valid, q_pop;
  pse_cmd_t         push_cmd, q_head;
  logic             wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_HEIGHT) ? {19'd0, height_r} :
                      (cfg_paddr == CFG_ADDR_WIDTH)  ? {19'd0, width_r}  : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd2;
      height_r <= 13'd1;
    end else if (wr) begin
      if (cfg_paddr == CFG_ADDR_WIDTH)  width_r  <= cfg_pwdata[DIM_W-1:0];
      if (cfg_paddr == CFG_ADDR_HEIGHT) height_r <= cfg_pwdata[DIM_W-1:0];
    end
  end

  pse_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .cfg_w(width_r), .cfg_h(height_r), .q_full, .push, .push_cmd
  );

  pse_queue u_queue (
    .clk, .rst_n, .push, .push_cmd, .full(q_full), .pop(q_pop),
    .valid(q_valid), .head(q_head)
  );

  pse_back #(.STORED_BLOCK_MAX(STORED_BLOCK_MAX)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd(q_head), .q_pop,
    .out_tready, .out_tvalid, .out_tdata, .out_tlast, .out_tuser
  );

endmodule
`default_nettype wire

/* hdl/pse_checker.sv */
// Port-level checks for the PNG stored greyscale encoder and their binding.
`default_nettype none
module pse_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast,
  input wire logic [0:0]  out_tuser,
  input wire logic        cfg_pready
);

  // The end of a file is also the end of the bytes released by that pixel.
  a_file_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("file_last without tlast");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled output changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind png_stored_greyscale_encoder pse_checker u_pse_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser, .cfg_pready
);
`default_nettype wire

/* tb/png_stored_greyscale_encoder_tb.sv */
// Self-checking testbench for the PNG stored greyscale encoder: pixel frames in, PNG bytes checked.
`default_nettype none
module png_stored_greyscale_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pse_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int N_ROWS = 24;

  typedef struct {
    logic [7:0] data;
    logic       run_end;
    logic       file_end;
  } png_byte_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  addr;
    logic [31:0] val;
    logic [7:0]  px;
    int          first;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic out_tvalid, out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tlast;
  logic [0:0] out_tuser;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  png_stored_greyscale_encoder dut (.*);

  always #6 clk = ~clk;

  // Model state.
  logic [12:0] width_reg, height_reg;
  bit          frame_open;
  int unsigned col_pos, row_pos, blk_left, raw_left, frame_w, frame_h;
  logic [31:0] crc_acc;
  int unsigned adler_a, adler_b;
  png_byte_t   png_bytes_due[$];
  png_byte_t   step_bytes[$];

  int errors = 0, pixels_sent = 0, bytes_seen = 0, frames_done = 0, stall_cnt = 0;
  bit no_idle = 1'b0;

  function automatic logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return c;
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo);
    if (v < lo) return lo;
    if (v > 4096) return 4096;
    return v;
  endfunction

  task automatic put_byte(logic [7:0] b, bit in_crc);
    png_byte_t e;
    if (in_crc) crc_acc = crc_update(crc_acc, b);
    e.data = b; e.run_end = 1'b0; e.file_end = 1'b0;
    if (step_bytes.size() < 50) step_bytes.push_back(e);
  endtask

  task automatic put_word(logic [31:0] v, bit in_crc);
    for (int i = 3; i >= 0; i--) put_byte(v[8*i +: 8], in_crc);
  endtask

  task automatic put_tag(logic [31:0] tag);
    crc_acc = 32'hFFFFFFFF;
    put_word(tag, 1'b1);
  endtask

  task automatic put_raw(logic [7:0] b);
    int unsigned n;
    if (raw_left == 0) return;
    if (blk_left == 0) begin
      n = (raw_left > 65535) ? 65535 : raw_left;
      put_byte((n == raw_left) ? 8'd1 : 8'd0, 1'b1);
      put_byte(n[7:0], 1'b1); put_byte(n[15:8], 1'b1);
      put_byte(~n[7:0], 1'b1); put_byte(~n[15:8], 1'b1);
      blk_left = n;
    end
    put_byte(b, 1'b1);
    adler_a += b;
    if (adler_a >= 65521) adler_a -= 65521;
    adler_b += adler_a;
    if (adler_b >= 65521) adler_b -= 65521;
    blk_left--;
    raw_left--;
  endtask

  // Works out every byte that one accepted pixel releases and queues them.
  task automatic encode_pixel(logic [7:0] px);
    int unsigned raw_len, nblk;
    step_bytes.delete();
    if (!frame_open) begin
      frame_w = clamp_dim(width_reg, 2);
      frame_h = clamp_dim(height_reg, 1);
      raw_len = (frame_w + 1) * frame_h;
      nblk = (raw_len + 65534) / 65535;
      put_word(32'h89504E47, 1'b0); put_word(32'h0D0A1A0A, 1'b0);
      put_word(32'd13, 1'b0);
      put_tag("IHDR");
      put_word(frame_w, 1'b1); put_word(frame_h, 1'b1);
      put_byte(8'd8, 1'b1);
      for (int i = 0; i < 4; i++) put_byte(8'd0, 1'b1);
      put_word(~crc_acc, 1'b0);
      put_word(2 + raw_len + 5 * nblk + 4, 1'b0);
      put_tag("IDAT");
      put_byte(8'h78, 1'b1); put_byte(8'h01, 1'b1);
      raw_left = raw_len; blk_left = 0;
      adler_a = 1; adler_b = 0;
      col_pos = 0; row_pos = 0;
      frame_open = 1'b1;
    end
    if (col_pos == 0) put_raw(8'd0);
    put_raw(px);
    col_pos++;
    if (col_pos >= frame_w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= frame_h) begin
        put_word({adler_b[15:0], adler_a[15:0]}, 1'b1);
        put_word(~crc_acc, 1'b0);
        put_word(32'd0, 1'b0);
        put_tag("IEND");
        put_word(~crc_acc, 1'b0);
        step_bytes[step_bytes.size()-1].file_end = 1'b1;
        frame_open = 1'b0;
        frames_done++;
      end
    end
    step_bytes[step_bytes.size()-1].run_end = 1'b1;
    foreach (step_bytes[i]) png_bytes_due.push_back(step_bytes[i]);
  endtask

  task automatic note_error(string what);
    errors++;
    if (errors <= 10) $display("MISMATCH %s", what);
  endtask

  // Lets the block finish its trailer before a register write.
  task automatic drain();
    while (png_bytes_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic apb_xfer(bit wr, logic [2:0] addr, logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_penable = 1'b0; cfg_pwrite = wr;
    cfg_paddr = addr; cfg_pwdata = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  task automatic write_dim(logic [2:0] addr, logic [31:0] v);
    logic [31:0] rd;
    drain();
    apb_xfer(1'b1, addr, v, rd);
    if (addr == CFG_ADDR_WIDTH) width_reg = v[12:0];
    else height_reg = v[12:0];
    apb_xfer(1'b0, addr, 32'd0, rd);
    if (rd[12:0] !== v[12:0]) note_error($sformatf("readback addr %0d exp %h got %h",
                                                   addr, v[12:0], rd[12:0]));
  endtask

  task automatic send_pixel(logic [7:0] px);
    if (!no_idle && $urandom_range(0, 2) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tvalid = 1'b1; in_tdata = px;
    do @(posedge clk); while (!in_tready);
    encode_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(int unsigned w, int unsigned h);
    for (int unsigned i = 0; i < clamp_dim(w, 2) * clamp_dim(h, 1); i++)
      send_pixel($urandom_range(0, 255));
    in_tvalid = 1'b0;
  endtask

  // Result side: random ready bursts, full rate when idling is switched off.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (no_idle) out_tready = 1'b1;
      else begin
        out_tready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
        out_tready = 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      bytes_seen++;
      if (png_bytes_due.size() == 0) note_error($sformatf("unexpected word %h", out_tdata));
      else begin
        png_byte_t e;
        e = png_bytes_due.pop_front();
        if (out_tdata !== e.data || out_tlast !== e.run_end || out_tuser[0] !== e.file_end)
          note_error($sformatf("word %0d exp %h/%b/%b got %h/%b/%b", bytes_seen, e.data,
                               e.run_end, e.file_end, out_tdata, out_tlast, out_tuser[0]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Timeout with %0d words still due", png_bytes_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  stim_row_t dir_tab [N_ROWS] = '{
    '{0, 3'd0, 32'd0, 8'h00, 8'h89}, '{0, 3'd0, 32'd0, 8'hFF, 8'hFF},
    '{1, CFG_ADDR_WIDTH, 32'd3, 8'h00, -1}, '{1, CFG_ADDR_HEIGHT, 32'd2, 8'h00, -1},
    '{0, 3'd0, 32'd0, 8'h80, 8'h89}, '{0, 3'd0, 32'd0, 8'h7F, 8'h7F},
    '{0, 3'd0, 32'd0, 8'h01, -1}, '{0, 3'd0, 32'd0, 8'hFE, -1},
    '{0, 3'd0, 32'd0, 8'h55, -1}, '{0, 3'd0, 32'd0, 8'hAA, -1},
    // Width zero and height zero clamp to a 2x1 frame.
    '{1, CFG_ADDR_WIDTH, 32'd0, 8'h00, -1}, '{1, CFG_ADDR_HEIGHT, 32'd0, 8'h00, -1},
    '{0, 3'd0, 32'd0, 8'h12, 8'h89}, '{0, 3'd0, 32'd0, 8'h34, -1},
    '{1, CFG_ADDR_WIDTH, 32'd1, 8'h00, -1},
    '{0, 3'd0, 32'd0, 8'h00, 8'h89}, '{0, 3'd0, 32'd0, 8'h00, -1},
    '{1, CFG_ADDR_WIDTH, 32'd2, 8'h00, -1}, '{1, CFG_ADDR_HEIGHT, 32'd2, 8'h00, -1},
    '{0, 3'd0, 32'd0, 8'h01, 8'h89},
    // A write in the middle of a frame must not change the open frame.
    '{1, CFG_ADDR_WIDTH, 32'hFFFF_E007, 8'h00, -1},
    '{0, 3'd0, 32'd0, 8'h02, 8'h02}, '{0, 3'd0, 32'd0, 8'h03, -1},
    '{0, 3'd0, 32'd0, 8'h04, -1}
  };

  initial begin
    int unsigned w, h;
    width_reg = 13'd2; height_reg = 13'd1; frame_open = 1'b0;
    col_pos = 0; row_pos = 0; blk_left = 0; raw_left = 0;
    crc_acc = 32'hFFFFFFFF; adler_a = 1; adler_b = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_dim(dir_tab[i].addr, dir_tab[i].val);
      else begin
        send_pixel(dir_tab[i].px);
        in_tvalid = 1'b0;
        if (dir_tab[i].first >= 0 && step_bytes[0].data !== dir_tab[i].first[7:0])
          note_error($sformatf("row %0d first word exp %h got %h", i,
                               dir_tab[i].first[7:0], step_bytes[0].data));
      end
    end

    while (pixels_sent < 200) begin
      w = $urandom_range(2, 9);
      h = $urandom_range(1, 4);
      if ($urandom_range(0, 5) == 0) w = $urandom_range(0, 1);
      if ($urandom_range(0, 5) == 0) h = 0;
      write_dim(CFG_ADDR_WIDTH, ($urandom & 32'hFFFF_E000) | w);
      write_dim(CFG_ADDR_HEIGHT, ($urandom & 32'hFFFF_E000) | h);
      send_frame(w, h);
    end

    // Full-rate part: a small complete frame, then an oversized width that clamps to the
    // maximum, whose frame is left open after its first pixels.
    no_idle = 1'b1;
    write_dim(CFG_ADDR_WIDTH, 32'd5);
    write_dim(CFG_ADDR_HEIGHT, 32'd3);
    send_frame(5, 3);
    write_dim(CFG_ADDR_WIDTH, 32'h1FFF);
    write_dim(CFG_ADDR_HEIGHT, 32'd0);
    repeat (32) send_pixel($urandom_range(0, 255));
    in_tvalid = 1'b0;

    while (png_bytes_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d pixels in %0d frames, checked %0d PNG words.",
             pixels_sent, frames_done, bytes_seen);
    $display("Covered clamped sizes, mid-frame writes, back-to-back traffic and maximum width.");
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
